// ----- src/vcs_pkg.sv -----
// Shared types and constants for the voxel color store.
// Holds the item structs, command and register codes, and the task record
// passed from the front end to the back end. No dependencies.
`default_nettype none

package vcs_pkg;

    localparam int CFG_DW   = 5;
    localparam int CFG_IW   = 2;
    localparam int COLOR_W  = 8;
    localparam int LIN_W    = 12;
    localparam int CNT_W    = 13;
    localparam int CNT_LIMIT = 8191;

    localparam logic [CFG_DW-1:0] CFG_SIZE_RESET = 5'd16;

    localparam logic [CFG_IW-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [2:0] CMD_SET_XYZ   = 3'd0;
    localparam logic [2:0] CMD_SET_IDX   = 3'd1;
    localparam logic [2:0] CMD_READ      = 3'd2;
    localparam logic [2:0] CMD_CLEAR     = 3'd3;
    localparam logic [2:0] CMD_CLEAR_ALL = 3'd4;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [7:0]  coord_x;
        logic signed [7:0]  coord_y;
        logic signed [7:0]  coord_z;
        logic [LIN_W-1:0]   lin_index;
        logic [COLOR_W-1:0] new_color;
        logic               padding_flag;
        logic               batch_last;
    } in_item_t;

    typedef struct packed {
        logic               accepted;
        logic               differs;
        logic [COLOR_W-1:0] color_out;
        logic [CNT_W-1:0]   active_total;
        logic               out_of_range;
        logic [CNT_W-1:0]   batch_total;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_SET,
        OP_READ,
        OP_CLEAR,
        OP_CLEAR_ALL
    } op_t;

    typedef struct packed {
        op_t                op;
        logic               oor;
        logic [COLOR_W-1:0] color;
        logic               pad;
        logic               last;
    } task_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_CLEAR
    } bk_state_t;

endpackage

`default_nettype wire

// ----- src/voxel_color_store_with_count_core.sv -----
// Top level of the voxel color store with active-voxel count.
// Connects vcs_front, vcs_queue and vcs_back. Uses vcs_pkg.
//
//   channel   ports                       direction  accepted when
//   input     s_valid s_ready s_item      in         s_valid && s_ready
//   result    m_valid m_ready m_item      out        m_valid && m_ready
//   config    cfg_we cfg_index cfg_wdata  in         cfg_we
//
// An item's entry is read into rd_reg when the back end takes the item; the entry is written
// and the result registered when the item executes, so a result passes the front stage, the
// queue, the back-end task register and the result register. Reads overlap writes, so items
// stream at one per cycle while results are taken at once. Clear all sweeps the memory,
// one entry per cycle. After reset the same sweep runs and s_ready stays low.
// A stalled result stops the back end; up to three items wait in front of it.
`default_nettype none

module voxel_color_store_with_count_core #(
    parameter int MAX_DIM     = 16,
    parameter int STORE_DEPTH = 4096
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [vcs_pkg::CFG_IW-1:0]  cfg_index,
    input  wire logic [vcs_pkg::CFG_DW-1:0]  cfg_wdata,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire vcs_pkg::in_item_t           s_item,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output vcs_pkg::out_item_t               m_item
);
    import vcs_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int TW = $bits(task_t);
    localparam int DW = AW + TW;

    logic          push_valid, push_ready;
    task_t         push_task;
    logic [AW-1:0] push_addr;
    logic          pop_valid, pop_ready;
    logic [DW-1:0] q_din, q_dout;
    task_t         pop_task;
    logic [AW-1:0] pop_addr;
    logic          busy;

    vcs_front #(
        .MAX_DIM     (MAX_DIM),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .hold       (busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_task  (push_task),
        .push_addr  (push_addr)
    );

    assign q_din = {push_addr, push_task};

    vcs_queue #(
        .DW (DW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (q_din),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (q_dout)
    );

    assign pop_task = task_t'(q_dout[TW-1:0]);
    assign pop_addr = q_dout[DW-1:TW];

    vcs_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_task  (pop_task),
        .pop_addr  (pop_addr),
        .busy      (busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire

// ----- src/vcs_front.sv -----
// Front end: size registers, item intake, address computation and range check.
// Turns each input item into a task record and memory address. Uses vcs_pkg.
`default_nettype none

module vcs_front #(
    parameter int MAX_DIM     = 16,
    parameter int STORE_DEPTH = 4096
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [vcs_pkg::CFG_IW-1:0]     cfg_index,
    input  wire logic [vcs_pkg::CFG_DW-1:0]     cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire vcs_pkg::in_item_t              s_item,
    input  wire logic                           hold,
    output logic                                push_valid,
    input  wire logic                           push_ready,
    output vcs_pkg::task_t                      push_task,
    output logic [$clog2(STORE_DEPTH)-1:0]      push_addr
);
    import vcs_pkg::*;

    localparam int EXT_W  = $clog2(MAX_DIM + 1);
    localparam int PROD_W = 3 * EXT_W;
    localparam int AW     = $clog2(STORE_DEPTH);

    function automatic logic [EXT_W-1:0] clamp_extent(input logic [CFG_DW-1:0] size);
        logic [EXT_W-1:0] r;
        if (32'(size) > MAX_DIM) begin
            r = EXT_W'(MAX_DIM);
        end else begin
            r = EXT_W'(size);
        end
        return r;
    endfunction

    logic [CFG_DW-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [EXT_W-1:0]  ex, ey, ez;

    logic s_fire;
    logic xyz_ok_next;
    logic [2*EXT_W-1:0] yex_next, exy_next;

    logic                 s1_valid_reg, s1_valid_next;
    logic [2:0]           s1_cmd_reg;
    logic                 s1_xyz_ok_reg;
    logic [EXT_W-1:0]     s1_x_reg, s1_z_reg, s1_ez_reg;
    logic [2*EXT_W-1:0]   s1_yex_reg, s1_exy_reg;
    logic [LIN_W-1:0]     s1_lin_reg;
    logic [COLOR_W-1:0]   s1_color_reg;
    logic                 s1_pad_reg, s1_last_reg;

    logic [PROD_W-1:0] zexy, total, coord_idx;
    logic              coord_ok, lin_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= CFG_SIZE_RESET;
            size_y_reg <= CFG_SIZE_RESET;
            size_z_reg <= CFG_SIZE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SIZE_X: size_x_reg <= cfg_wdata;
                CFG_SIZE_Y: size_y_reg <= cfg_wdata;
                CFG_SIZE_Z: size_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign ex = clamp_extent(size_x_reg);
    assign ey = clamp_extent(size_y_reg);
    assign ez = clamp_extent(size_z_reg);

    assign s_ready = !hold && (!s1_valid_reg || push_ready);
    assign s_fire  = s_valid && s_ready;

    assign xyz_ok_next = !s_item.coord_x[7] && (32'(s_item.coord_x[6:0]) < 32'(ex)) &&
                         !s_item.coord_y[7] && (32'(s_item.coord_y[6:0]) < 32'(ey)) &&
                         !s_item.coord_z[7] && (32'(s_item.coord_z[6:0]) < 32'(ez));
    assign yex_next = (2*EXT_W)'(s_item.coord_y[EXT_W-1:0]) * (2*EXT_W)'(ex);
    assign exy_next = (2*EXT_W)'(ex) * (2*EXT_W)'(ey);

    assign s1_valid_next = s_fire ? 1'b1 : (push_ready ? 1'b0 : s1_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_cmd_reg    <= s_item.command;
            s1_xyz_ok_reg <= xyz_ok_next;
            s1_x_reg      <= s_item.coord_x[EXT_W-1:0];
            s1_z_reg      <= s_item.coord_z[EXT_W-1:0];
            s1_ez_reg     <= ez;
            s1_yex_reg    <= yex_next;
            s1_exy_reg    <= exy_next;
            s1_lin_reg    <= s_item.lin_index;
            s1_color_reg  <= s_item.new_color;
            s1_pad_reg    <= s_item.padding_flag;
            s1_last_reg   <= s_item.batch_last;
        end
    end

    assign zexy      = PROD_W'(s1_z_reg) * PROD_W'(s1_exy_reg);
    assign total     = PROD_W'(s1_exy_reg) * PROD_W'(s1_ez_reg);
    assign coord_idx = PROD_W'(s1_x_reg) + PROD_W'(s1_yex_reg) + zexy;
    assign coord_ok  = s1_xyz_ok_reg && (32'(coord_idx) < STORE_DEPTH);
    assign lin_ok    = (32'(s1_lin_reg) < 32'(total)) && (32'(s1_lin_reg) < STORE_DEPTH);

    assign push_valid = s1_valid_reg;

    always_comb begin
        push_task       = '0;
        push_task.op    = OP_NOP;
        push_task.color = s1_color_reg;
        push_task.pad   = s1_pad_reg;
        push_task.last  = s1_last_reg;
        push_addr       = AW'(coord_idx);
        case (s1_cmd_reg)
            CMD_SET_XYZ: begin
                push_task.op  = OP_SET;
                push_task.oor = !coord_ok;
            end
            CMD_SET_IDX: begin
                push_task.op  = OP_SET;
                push_task.oor = !lin_ok;
                push_addr     = AW'(s1_lin_reg);
            end
            CMD_READ: begin
                push_task.op  = OP_READ;
                push_task.oor = !coord_ok;
            end
            CMD_CLEAR: begin
                push_task.op  = OP_CLEAR;
                push_task.oor = !coord_ok;
            end
            CMD_CLEAR_ALL: begin
                push_task.op  = OP_CLEAR_ALL;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/vcs_queue.sv -----
// Two-entry queue between the front end and the back end.
// Carries a flat word of task record and address. No package dependencies.
`default_nettype none

module vcs_queue #(
    parameter int DW = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire logic [DW-1:0] push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output logic [DW-1:0]      pop_data
);
    localparam int DEPTH = 2;

    logic [DW-1:0] slot_reg [DEPTH];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          push, pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(DEPTH))
        else $error("queue count above depth");
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not rise on push");
    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - 2'd1)
        else $error("queue count did not fall on pop");
`endif

endmodule

`default_nettype wire

// ----- src/vcs_back.sv -----
// Back end: color memory, read-modify-write sequencer, counters, clear sweep
// and the result register. Uses vcs_pkg.
`default_nettype none

module vcs_back #(
    parameter int STORE_DEPTH = 4096
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           pop_valid,
    output logic                                pop_ready,
    input  wire vcs_pkg::task_t                 pop_task,
    input  wire logic [$clog2(STORE_DEPTH)-1:0] pop_addr,
    output logic                                busy,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output vcs_pkg::out_item_t                  m_item
);
    import vcs_pkg::*;

    localparam int AW        = $clog2(STORE_DEPTH);
    localparam int COUNT_CAP = (STORE_DEPTH < CNT_LIMIT) ? STORE_DEPTH : CNT_LIMIT;

    logic [COLOR_W-1:0] mem [STORE_DEPTH];

    bk_state_t          state_reg, state_next;
    task_t              cur_reg;
    logic [AW-1:0]      cur_addr_reg;
    logic [COLOR_W-1:0] rd_reg;
    logic               fwd_reg, fwd_next;
    logic [COLOR_W-1:0] fwd_data_reg;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]   active_reg, active_next;
    logic [CNT_W-1:0]   batch_reg, batch_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_item_reg;

    logic               out_free, exec_done, pop_fire, clr_last;
    logic [COLOR_W-1:0] old;
    out_item_t          res;
    logic [CNT_W-1:0]   act_n, bat_n;
    logic               ex_wr;
    logic [COLOR_W-1:0] ex_wdata;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [COLOR_W-1:0] mem_wdata;

    assign out_free  = !m_valid_reg || m_ready;
    assign exec_done = (state_reg == BK_EXEC) && out_free;
    assign pop_fire  = pop_valid && pop_ready;
    assign clr_last  = (clr_addr_reg == AW'(STORE_DEPTH - 1));
    assign old       = fwd_reg ? fwd_data_reg : rd_reg;

    always_comb begin
        res      = '0;
        act_n    = active_reg;
        bat_n    = batch_reg;
        ex_wr    = 1'b0;
        ex_wdata = '0;
        case (cur_reg.op)
            OP_SET: begin
                if (cur_reg.oor) begin
                    res.out_of_range = 1'b1;
                end else begin
                    res.color_out = old;
                    if (old != cur_reg.color) begin
                        if (old == '0 && !cur_reg.pad) begin
                            if (active_reg < CNT_W'(COUNT_CAP)) begin
                                act_n = active_reg + CNT_W'(1);
                            end
                        end else if (cur_reg.color == '0 && !cur_reg.pad) begin
                            if (active_reg != '0) begin
                                act_n = active_reg - CNT_W'(1);
                            end
                        end
                        ex_wr        = 1'b1;
                        ex_wdata     = cur_reg.color;
                        res.accepted = 1'b1;
                        res.differs  = 1'b1;
                        if (batch_reg < CNT_W'(COUNT_CAP)) begin
                            bat_n = batch_reg + CNT_W'(1);
                        end
                    end
                end
                if (cur_reg.last) begin
                    res.batch_total = bat_n;
                    bat_n = '0;
                end
            end
            OP_READ, OP_CLEAR: begin
                if (cur_reg.oor) begin
                    res.out_of_range = 1'b1;
                end else begin
                    res.color_out = old;
                    res.accepted  = 1'b1;
                    if (cur_reg.op == OP_CLEAR) begin
                        ex_wr = 1'b1;
                    end
                end
            end
            OP_CLEAR_ALL: begin
                act_n        = '0;
                res.accepted = 1'b1;
            end
            default: ;
        endcase
        res.active_total = act_n;
    end

    // Outputs of the sequencer.
    always_comb begin
        pop_ready     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = cur_addr_reg;
        mem_wdata     = ex_wdata;
        fwd_next      = 1'b0;
        clr_addr_next = clr_addr_reg;
        active_next   = active_reg;
        batch_next    = batch_reg;
        case (state_reg)
            BK_IDLE: begin
                pop_ready = 1'b1;
            end
            BK_EXEC: begin
                if (out_free) begin
                    pop_ready   = (cur_reg.op != OP_CLEAR_ALL);
                    mem_we      = ex_wr;
                    fwd_next    = ex_wr && (pop_addr == cur_addr_reg);
                    active_next = act_n;
                    batch_next  = bat_n;
                end
            end
            BK_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_last ? '0 : clr_addr_reg + AW'(1);
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (pop_valid) begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (out_free) begin
                    if (cur_reg.op == OP_CLEAR_ALL) begin
                        state_next = BK_CLEAR;
                    end else if (pop_valid) begin
                        state_next = BK_EXEC;
                    end else begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_CLEAR: begin
                if (clr_last) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign m_valid_next = exec_done ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_CLEAR;
            clr_addr_reg <= '0;
            active_reg   <= '0;
            batch_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            active_reg   <= active_next;
            batch_reg    <= batch_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_fire) begin
            cur_reg      <= pop_task;
            cur_addr_reg <= pop_addr;
            fwd_reg      <= fwd_next;
            fwd_data_reg <= ex_wdata;
        end
        if (exec_done) begin
            m_item_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (pop_fire) begin
            rd_reg <= mem[pop_addr];
        end
    end

    assign busy    = (state_reg == BK_CLEAR);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef ASSERT_OFF
    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_CLEAR) |-> !pop_ready)
        else $error("task taken during clear sweep");
    a_clear_all_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_done && cur_reg.op == OP_CLEAR_ALL) |=>
            (state_reg == BK_CLEAR) && (active_reg == '0) && (clr_addr_reg == '0))
        else $error("clear all did not start a sweep");
    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == BK_EXEC)
        else $error("result raised outside execution");
`endif

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for voxel_color_store_with_count_core.
// Drives random and directed items through the valid/ready channels and checks every
// result against a built-in predictor of the voxel store; depends on vcs_pkg.
module tb;
    import vcs_pkg::*;

    localparam int MAX_DIM     = 16;
    localparam int STORE_DEPTH = 4096;
    localparam int COUNT_CAP   = (STORE_DEPTH < CNT_LIMIT) ? STORE_DEPTH : CNT_LIMIT;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 80;

    class voxel_tracker;
        bit [COLOR_W-1:0] colors [STORE_DEPTH];
        int unsigned active_cnt;
        int unsigned batch_cnt;
        bit [CFG_DW-1:0] size_x, size_y, size_z;
        out_item_t awaited [$];
        int unsigned errors;

        function new();
            foreach (colors[i]) colors[i] = '0;
            active_cnt = 0;
            batch_cnt = 0;
            size_x = CFG_SIZE_RESET;
            size_y = CFG_SIZE_RESET;
            size_z = CFG_SIZE_RESET;
            errors = 0;
        endfunction

        function int unsigned dim(bit [CFG_DW-1:0] s);
            return (s > MAX_DIM) ? MAX_DIM : s;
        endfunction

        function void set_size(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_SIZE_X: size_x = val;
                CFG_SIZE_Y: size_y = val;
                CFG_SIZE_Z: size_z = val;
                default: ;
            endcase
        endfunction

        function bit locate(in_item_t it, output int unsigned idx);
            int x, y, z;
            int unsigned ex, ey, ez;
            x = $signed(it.coord_x);
            y = $signed(it.coord_y);
            z = $signed(it.coord_z);
            ex = dim(size_x);
            ey = dim(size_y);
            ez = dim(size_z);
            idx = 0;
            if (x < 0 || y < 0 || z < 0) return 0;
            if (x >= ex || y >= ey || z >= ez) return 0;
            idx = x + y * ex + z * ex * ey;
            return idx < STORE_DEPTH;
        endfunction

        function void note_command(in_item_t it);
            out_item_t r;
            int unsigned idx;
            bit ok;
            bit [COLOR_W-1:0] prior;
            r = '0;
            case (it.command)
                CMD_SET_XYZ, CMD_SET_IDX: begin
                    if (it.command == CMD_SET_XYZ) begin
                        ok = locate(it, idx);
                    end else begin
                        idx = it.lin_index;
                        ok = idx < dim(size_x) * dim(size_y) * dim(size_z) && idx < STORE_DEPTH;
                    end
                    if (!ok) begin
                        r.out_of_range = 1'b1;
                    end else begin
                        prior = colors[idx];
                        r.color_out = prior;
                        if (prior != it.new_color) begin
                            if (prior == 0 && !it.padding_flag) begin
                                if (active_cnt < COUNT_CAP) active_cnt++;
                            end else if (it.new_color == 0 && !it.padding_flag) begin
                                if (active_cnt > 0) active_cnt--;
                            end
                            colors[idx] = it.new_color;
                            r.accepted = 1'b1;
                            r.differs = 1'b1;
                            if (batch_cnt < COUNT_CAP) batch_cnt++;
                        end
                    end
                    if (it.batch_last) begin
                        r.batch_total = CNT_W'(batch_cnt);
                        batch_cnt = 0;
                    end
                end
                CMD_READ, CMD_CLEAR: begin
                    if (!locate(it, idx)) begin
                        r.out_of_range = 1'b1;
                    end else begin
                        r.color_out = colors[idx];
                        r.accepted = 1'b1;
                        if (it.command == CMD_CLEAR) colors[idx] = '0;
                    end
                end
                CMD_CLEAR_ALL: begin
                    foreach (colors[i]) colors[i] = '0;
                    active_cnt = 0;
                    r.accepted = 1'b1;
                end
                default: ;
            endcase
            r.active_total = CNT_W'(active_cnt);
            awaited.push_back(r);
        endfunction

        function int field_diff(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (got === want) return 0;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            return 1;
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            errors += field_diff("accepted", CNT_W'(want.accepted), CNT_W'(got.accepted));
            errors += field_diff("differs", CNT_W'(want.differs), CNT_W'(got.differs));
            errors += field_diff("color_out", CNT_W'(want.color_out), CNT_W'(got.color_out));
            errors += field_diff("active_total", want.active_total, got.active_total);
            errors += field_diff("out_of_range", CNT_W'(want.out_of_range),
                                 CNT_W'(got.out_of_range));
            errors += field_diff("batch_total", want.batch_total, got.batch_total);
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_item = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_item;

    voxel_tracker tracker;
    int unsigned  send_idle_pct = 32;
    int unsigned  recv_idle_pct = 49;
    int unsigned  cycle_count = 0;

    voxel_color_store_with_count_core #(
        .MAX_DIM(MAX_DIM),
        .STORE_DEPTH(STORE_DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item(s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item(m_item)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_result(m_item);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic in_item_t make_item(logic [2:0] cmd, int x, int y, int z, int idx,
                                           int color, bit pad, bit last);
        in_item_t it;
        it.command = cmd;
        it.coord_x = 8'(x);
        it.coord_y = 8'(y);
        it.coord_z = 8'(z);
        it.lin_index = LIN_W'(idx);
        it.new_color = COLOR_W'(color);
        it.padding_flag = pad;
        it.batch_last = last;
        return it;
    endfunction

    function automatic logic [7:0] pick_coord(int unsigned e);
        if (e == 0 || $urandom_range(0, 99) < 15) return 8'($urandom);
        return 8'($urandom_range(0, e - 1));
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int unsigned r;
        int unsigned total;
        r = $urandom_range(0, 99);
        if (r < 38) it.command = CMD_SET_XYZ;
        else if (r < 58) it.command = CMD_SET_IDX;
        else if (r < 75) it.command = CMD_READ;
        else if (r < 90) it.command = CMD_CLEAR;
        else if (r < 92) it.command = CMD_CLEAR_ALL;
        else it.command = CMD_CLEAR_ALL + 3'($urandom_range(1, 3));
        it.coord_x = pick_coord(tracker.dim(tracker.size_x));
        it.coord_y = pick_coord(tracker.dim(tracker.size_y));
        it.coord_z = pick_coord(tracker.dim(tracker.size_z));
        total = tracker.dim(tracker.size_x) * tracker.dim(tracker.size_y)
              * tracker.dim(tracker.size_z);
        if (total == 0 || $urandom_range(0, 99) < 15) it.lin_index = LIN_W'($urandom);
        else it.lin_index = LIN_W'($urandom_range(0, total - 1));
        r = $urandom_range(0, 99);
        if (r < 25) it.new_color = '0;
        else if (r < 70) it.new_color = COLOR_W'($urandom_range(1, 3));
        else it.new_color = COLOR_W'($urandom);
        it.padding_flag = ($urandom_range(0, 99) < 20);
        it.batch_last = ($urandom_range(0, 99) < 15);
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_command(it);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_sizes(bit [CFG_DW-1:0] sx, bit [CFG_DW-1:0] sy, bit [CFG_DW-1:0] sz);
        logic [CFG_IW-1:0] regs [3];
        bit [CFG_DW-1:0] vals [3];
        regs = '{CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z};
        vals = '{sx, sy, sz};
        for (int i = 0; i < 3; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            tracker.set_size(regs[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    bit [CFG_DW-1:0] grid_sets [PHASES][3] = '{
        '{5'd2, 5'd2, 5'd2}, '{5'd1, 5'd1, 5'd1}, '{5'd4, 5'd2, 5'd8},
        '{5'd0, 5'd16, 5'd16}, '{5'd31, 5'd3, 5'd5}, '{5'd16, 5'd1, 5'd16},
        '{5'd3, 5'd7, 5'd16}, '{5'd16, 5'd16, 5'd16}
    };

    initial begin
        tracker = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items on the full 16x16x16 grid left by reset.
        send_item(make_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_SET_XYZ, 0, 0, 0, 0, 255, 0, 0));
        send_item(make_item(CMD_SET_XYZ, 0, 0, 0, 0, 255, 0, 0));
        send_item(make_item(CMD_SET_XYZ, 15, 15, 15, 0, 1, 0, 1));
        send_item(make_item(CMD_SET_IDX, 0, 0, 0, 4095, 128, 1, 0));
        send_item(make_item(CMD_SET_IDX, 0, 0, 0, 4095, 0, 0, 0));
        send_item(make_item(CMD_SET_XYZ, -1, 0, 0, 0, 9, 0, 0));
        send_item(make_item(CMD_SET_XYZ, -128, 127, 0, 0, 9, 0, 1));
        send_item(make_item(CMD_SET_XYZ, 16, 0, 0, 0, 9, 0, 0));
        send_item(make_item(CMD_READ, 15, 15, 15, 0, 0, 0, 0));
        send_item(make_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_CLEAR, 0, -1, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_READ, 0, 0, 16, 0, 0, 0, 1));
        send_item(make_item(CMD_CLEAR_ALL + 3'd1, 1, 1, 1, 1, 1, 1, 1));
        send_item(make_item(CMD_CLEAR_ALL + 3'd2, 0, 0, 0, 0, 0, 0, 1));
        send_item(make_item(CMD_CLEAR_ALL + 3'd3, -1, -1, -1, 4095, 255, 1, 1));
        send_item(make_item(CMD_SET_IDX, 0, 0, 0, 1, 5, 0, 0));
        send_item(make_item(CMD_CLEAR_ALL, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_READ, 1, 0, 0, 0, 0, 0, 0));
        send_item(make_item(CMD_SET_IDX, 0, 0, 0, 100, 7, 1, 0));
        send_item(make_item(CMD_SET_IDX, 0, 0, 0, 100, 0, 0, 1));
        send_item(make_item(CMD_SET_IDX, 0, 0, 0, 100, 0, 0, 1));
        send_item(make_item(CMD_SET_XYZ, 127, 127, 127, 0, 3, 0, 1));

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            if (p < 3) begin
                send_idle_pct = 32;
                recv_idle_pct = 49;
            end else if (p < 6) begin
                send_idle_pct = 49;
                recv_idle_pct = 32;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_sizes(grid_sets[p][0], grid_sets[p][1], grid_sets[p][2]);
            repeat (PHASE_ITEMS) send_item(random_item());
        end

        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
